FILE: hdl/iepb_pkg.sv
`timescale 1ns / 1ps
package iepb_pkg;

    localparam int PAYLOAD_BYTES = 21;
    localparam int ROM_BYTES     = 36;
    localparam int PAYLOAD_LEN   = (PAYLOAD_BYTES > ROM_BYTES) ? ROM_BYTES : PAYLOAD_BYTES;
    localparam int PKT_BYTES     = 28 + PAYLOAD_LEN;

    localparam int OFF_W = 6;
    localparam logic [OFF_W-1:0] LAST_OFFSET = OFF_W'(PKT_BYTES - 1);
    localparam logic [OFF_W-1:0] PAYLOAD_BASE = OFF_W'(28);

    localparam logic [7:0]  VER_IHL    = 8'h45;
    localparam logic [7:0]  TTL        = 8'd64;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  ECHO_REQ   = 8'd8;
    localparam logic [15:0] TOTAL_LEN  = 16'(PKT_BYTES);
    localparam logic [15:0] ID_RESET   = 16'h7601;

    localparam logic [1:0] REG_SRC = 2'd0;
    localparam logic [1:0] REG_DST = 2'd1;
    localparam logic [1:0] REG_ID  = 2'd2;

    localparam logic [7:0] PAYLOAD_ROM [ROM_BYTES] = '{
        8'h76, 8'h6D, 8'h73, 8'h67, 8'h75, 8'h61, 8'h72, 8'h64, 8'h20,
        8'h69, 8'h6E, 8'h6A, 8'h65, 8'h63, 8'h74, 8'h20,
        8'h70, 8'h72, 8'h6F, 8'h62, 8'h65,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] id;
    } cfg_t;

    typedef struct packed {
        logic [15:0] seq;
        logic [15:0] hdr_ck;
        logic [15:0] icmp_ck;
    } ctx_t;

    // end-around carry fold, not complemented
    function automatic logic [15:0] fold16(input logic [31:0] x);
        logic [16:0] a;
        logic [16:0] b;
        logic [16:0] c;
        a = {1'b0, x[31:16]} + {1'b0, x[15:0]};
        b = {16'h0, a[16]} + {1'b0, a[15:0]};
        c = {16'h0, b[16]} + {1'b0, b[15:0]};
        return c[15:0];
    endfunction

    function automatic logic [31:0] payload_sum();
        logic [31:0] acc;
        logic [7:0]  lo;
        acc = 32'h0;
        for (int k = 0; k < PAYLOAD_LEN; k += 2) begin
            lo  = (k + 1 < PAYLOAD_LEN) ? PAYLOAD_ROM[k+1] : 8'h00;
            acc = acc + {16'h0, PAYLOAD_ROM[k], lo};
        end
        return acc;
    endfunction

    localparam logic [15:0] HDR_CONST  = fold16(32'h4500 + 32'(PKT_BYTES) + 32'h4001);
    localparam logic [15:0] ICMP_CONST = fold16(32'h0800 + payload_sum());

    function automatic logic [7:0] rom_byte(input logic [5:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (32'(idx) < PAYLOAD_LEN) begin
            b = PAYLOAD_ROM[idx];
        end
        return b;
    endfunction

endpackage

FILE: hdl/iepb_cfg.sv
`timescale 1ns / 1ps
module iepb_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output iepb_pkg::cfg_t     cfg
);
    import iepb_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src <= '0;
            cfg_reg.dst <= '0;
            cfg_reg.id  <= ID_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SRC: cfg_reg.src <= cfg_data;
                REG_DST: cfg_reg.dst <= cfg_data;
                REG_ID:  cfg_reg.id  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: hdl/iepb_cksum.sv
`timescale 1ns / 1ps
module iepb_cksum (
    input  iepb_pkg::cfg_t  cfg,
    input  logic [15:0]     seq,
    output iepb_pkg::ctx_t  ctx
);
    import iepb_pkg::*;

    logic [19:0] hdr_sum;
    logic [17:0] icmp_sum;

    always_comb begin
        hdr_sum = 20'(HDR_CONST) + 20'(cfg.id)
                + 20'(cfg.src[31:16]) + 20'(cfg.src[15:0])
                + 20'(cfg.dst[31:16]) + 20'(cfg.dst[15:0]);
        icmp_sum = 18'(ICMP_CONST) + 18'(cfg.id) + 18'(seq);
        ctx.seq     = seq;
        ctx.hdr_ck  = ~fold16({12'h0, hdr_sum});
        ctx.icmp_ck = ~fold16({14'h0, icmp_sum});
    end

endmodule

FILE: hdl/iepb_emit.sv
`timescale 1ns / 1ps
module iepb_emit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  iepb_pkg::ctx_t           in_ctx,
    input  iepb_pkg::cfg_t           cfg,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [7:0]               out_byte,
    output logic [iepb_pkg::OFF_W-1:0] out_offset,
    output logic                     out_last
);
    import iepb_pkg::*;

    ctx_t             ctx_reg;
    logic             ctx_valid_reg;
    logic [OFF_W-1:0] off_reg;
    logic             m_valid_reg;
    logic [7:0]       m_byte_reg;
    logic [OFF_W-1:0] m_off_reg;
    logic             m_last_reg;

    logic             advance;
    logic             at_last;
    logic             load;
    logic [7:0]       byte_next;

    assign advance  = ctx_valid_reg && (!m_valid_reg || out_ready);
    assign at_last  = (off_reg == LAST_OFFSET);
    assign in_ready = !ctx_valid_reg || (advance && at_last);
    assign load     = in_valid && in_ready;

    always_comb begin
        case (off_reg)
            6'd0:    byte_next = VER_IHL;
            6'd2:    byte_next = TOTAL_LEN[15:8];
            6'd3:    byte_next = TOTAL_LEN[7:0];
            6'd4:    byte_next = cfg.id[15:8];
            6'd5:    byte_next = cfg.id[7:0];
            6'd8:    byte_next = TTL;
            6'd9:    byte_next = PROTO_ICMP;
            6'd10:   byte_next = ctx_reg.hdr_ck[15:8];
            6'd11:   byte_next = ctx_reg.hdr_ck[7:0];
            6'd12:   byte_next = cfg.src[31:24];
            6'd13:   byte_next = cfg.src[23:16];
            6'd14:   byte_next = cfg.src[15:8];
            6'd15:   byte_next = cfg.src[7:0];
            6'd16:   byte_next = cfg.dst[31:24];
            6'd17:   byte_next = cfg.dst[23:16];
            6'd18:   byte_next = cfg.dst[15:8];
            6'd19:   byte_next = cfg.dst[7:0];
            6'd20:   byte_next = ECHO_REQ;
            6'd22:   byte_next = ctx_reg.icmp_ck[15:8];
            6'd23:   byte_next = ctx_reg.icmp_ck[7:0];
            6'd24:   byte_next = cfg.id[15:8];
            6'd25:   byte_next = cfg.id[7:0];
            6'd26:   byte_next = ctx_reg.seq[15:8];
            6'd27:   byte_next = ctx_reg.seq[7:0];
            6'd1, 6'd6, 6'd7, 6'd21: byte_next = 8'h00;
            default: byte_next = rom_byte(off_reg - PAYLOAD_BASE);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_valid_reg <= 1'b0;
            off_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (load) begin
                ctx_valid_reg <= 1'b1;
                off_reg       <= '0;
            end else if (advance) begin
                ctx_valid_reg <= !at_last;
                off_reg       <= at_last ? '0 : off_reg + 1'b1;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ctx_reg <= in_ctx;
        end
        if (advance) begin
            m_byte_reg <= byte_next;
            m_off_reg  <= off_reg;
            m_last_reg <= at_last;
        end
    end

    assign out_valid  = m_valid_reg;
    assign out_byte   = m_byte_reg;
    assign out_offset = m_off_reg;
    assign out_last   = m_last_reg;

    a_last_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_off_reg == LAST_OFFSET))
        else $error("last item without final offset");

    a_offset_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_ready && !m_last_reg)
        |=> (m_valid_reg && m_off_reg == $past(m_off_reg) + 1'b1))
        else $error("gap in byte sequence");

    a_load_start: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (ctx_valid_reg && off_reg == '0))
        else $error("packet not started after accept");

endmodule

FILE: hdl/icmp_echo_packet_builder_core.sv
`timescale 1ns / 1ps
// icmp echo request builder
// s_ channel: one item per request, tdata holds the 16-bit echo sequence number.
// m_ channel: one item per packet byte in wire order, 28 + payload bytes (49);
//   tlast marks the final byte of each packet.
// cfg channel: cfg_index 0 source address, 1 destination address, 2 identifier;
//   always ready, other indexes ignored. write only while no packet is in flight.
// both checksums are formed as the request is accepted and kept with it.
// first byte: the accepting edge loads the context register, and the first byte then
//   goes from there to the output register, which drives m_.
// throughput: one byte per cycle while m_tready does not stall the output; the next request
//   is taken in the cycle the last byte of the current one goes to the output register,
//   so packets follow without a gap.
// receiver stall: the output register holds its byte and the byte counter waits;
//   s_tready stays low until the current packet has reached its final byte.
// reset: aresetn low clears all valid state, addresses go to zero, identifier to 0x7601.
module icmp_echo_packet_builder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] sequence_number
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] packet_byte, [13:8] byte_offset, [15:14] zero
    output logic        m_tlast,    // last_byte
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import iepb_pkg::*;

    cfg_t             cfg;
    ctx_t             new_ctx;
    logic [7:0]       out_byte;
    logic [OFF_W-1:0] out_offset;

    iepb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iepb_cksum u_cksum (
        .cfg (cfg),
        .seq (s_tdata),
        .ctx (new_ctx)
    );

    iepb_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_ctx     (new_ctx),
        .cfg        (cfg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (out_byte),
        .out_offset (out_offset),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, out_offset, out_byte};

endmodule

FILE: test/icmp_echo_packet_checker.sv
`timescale 1ns / 1ps
module icmp_echo_packet_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          error_count,
    output int          pending_bytes,
    output int          requests_seen,
    output int          bytes_checked
);
    import iepb_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic [5:0] offset;
        logic       last;
    } wire_byte_t;

    wire_byte_t  expected_bytes [$];
    wire_byte_t  next_byte;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] echo_id;
    logic [7:0]  packet_image [64];

    initial begin
        error_count   = 0;
        pending_bytes = 0;
        requests_seen = 0;
        bytes_checked = 0;
        src_addr      = 32'h0;
        dst_addr      = 32'h0;
        echo_id       = ID_RESET;
    end

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch at byte %0d: %s got 0x%0h, expected 0x%0h",
                 bytes_checked, what, got, want);
        error_count++;
    endtask

    // complemented ones'-complement sum over packet_image, odd tail padded with a zero low byte
    function automatic logic [15:0] ones_sum16(input int first, input int count);
        logic [31:0] acc;
        int          k;
        acc = 32'h0;
        for (k = 0; k + 1 < count; k += 2) begin
            acc = acc + {16'h0, packet_image[first+k], packet_image[first+k+1]};
        end
        if (k < count) begin
            acc = acc + {16'h0, packet_image[first+k], 8'h00};
        end
        while (acc[31:16] != 16'h0) begin
            acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        end
        return ~acc[15:0];
    endfunction

    function automatic void queue_echo_packet(input logic [15:0] seq);
        int          pkt_len;
        int          k;
        logic [15:0] total_len;
        logic [15:0] ck;
        wire_byte_t  b;
        pkt_len   = 28 + PAYLOAD_LEN;
        total_len = 16'(pkt_len);
        for (k = 0; k < 64; k++) begin
            packet_image[k] = 8'h00;
        end
        packet_image[0] = VER_IHL;
        packet_image[2] = total_len[15:8];
        packet_image[3] = total_len[7:0];
        packet_image[4] = echo_id[15:8];
        packet_image[5] = echo_id[7:0];
        packet_image[8] = TTL;
        packet_image[9] = PROTO_ICMP;
        for (k = 0; k < 4; k++) begin
            packet_image[12+k] = src_addr[31-8*k -: 8];
            packet_image[16+k] = dst_addr[31-8*k -: 8];
        end
        ck = ones_sum16(0, 20);
        packet_image[10] = ck[15:8];
        packet_image[11] = ck[7:0];
        packet_image[20] = ECHO_REQ;
        packet_image[24] = echo_id[15:8];
        packet_image[25] = echo_id[7:0];
        packet_image[26] = seq[15:8];
        packet_image[27] = seq[7:0];
        for (k = 0; k < PAYLOAD_LEN; k++) begin
            packet_image[28+k] = PAYLOAD_ROM[k];
        end
        ck = ones_sum16(20, 8 + PAYLOAD_LEN);
        packet_image[22] = ck[15:8];
        packet_image[23] = ck[7:0];
        for (k = 0; k < pkt_len; k++) begin
            b.value  = packet_image[k];
            b.offset = 6'(k);
            b.last   = (k == pkt_len - 1);
            expected_bytes.push_back(b);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_bytes.delete();
            src_addr = 32'h0;
            dst_addr = 32'h0;
            echo_id  = ID_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SRC: src_addr = cfg_data;
                    REG_DST: dst_addr = cfg_data;
                    REG_ID:  echo_id  = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                queue_echo_packet(s_tdata);
                requests_seen++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report("unexpected item", m_tdata, 16'h0);
                end else begin
                    next_byte = expected_bytes.pop_front();
                    if (m_tdata[7:0] !== next_byte.value) begin
                        report("packet_byte", {8'h0, m_tdata[7:0]}, {8'h0, next_byte.value});
                    end
                    if (m_tdata[13:8] !== next_byte.offset) begin
                        report("byte_offset", {10'h0, m_tdata[13:8]},
                               {10'h0, next_byte.offset});
                    end
                    if (m_tlast !== next_byte.last) begin
                        report("last_byte", {15'h0, m_tlast}, {15'h0, next_byte.last});
                    end
                    bytes_checked++;
                end
            end
        end
        pending_bytes = expected_bytes.size();
    end

endmodule

FILE: test/icmp_echo_packet_builder_core_tb.sv
`timescale 1ns / 1ps
module icmp_echo_packet_builder_core_tb;
    import iepb_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 100;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    int error_count;
    int pending_bytes;
    int requests_seen;
    int bytes_checked;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int config_writes;

    icmp_echo_packet_builder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    icmp_echo_packet_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_bytes (pending_bytes),
        .requests_seen (requests_seen),
        .bytes_checked (bytes_checked)
    );

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 16'h0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_SRC;
        cfg_data      = 32'h0;
        cycle_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        config_writes = 0;
    end

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, pending_bytes);
            $display("icmp_echo_packet_builder_core_tb: done, errors");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // entered and left at a falling edge; tvalid stays high until the next call or wait_idle
    task automatic send_request(input logic [15:0] seq);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= seq;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_bytes != 0) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        config_writes++;
    endtask

    task automatic configure(input logic [31:0] src, input logic [31:0] dst,
                             input logic [15:0] id);
        wait_idle();
        cfg_write(REG_SRC, src);
        cfg_write(REG_DST, dst);
        cfg_write(REG_ID, {16'($urandom_range(65535)), id});
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(4))
            0: v = 32'h0;
            1: v = 32'hFFFF_FFFF;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic random_phase(input int send_pct, input int recv_pct);
        logic [31:0] id_word;
        id_word       = pick_value();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        configure(pick_value(), pick_value(), id_word[15:0]);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(24) == 0) begin
                wait_idle();
                cfg_write(2'($urandom_range(3)), pick_value());
            end
            if ($urandom_range(9) == 0) begin
                send_request(($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF);
            end else begin
                send_request(16'($urandom_range(65535)));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 9;
        recv_idle_pct = 49;

        // reset values of the registers
        send_request(16'h0000);
        send_request(16'hFFFF);

        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(16'hFFFF);
        send_request(16'h0000);
        send_request(16'h8000);

        configure(32'h0, 32'h0, 16'h0000);
        send_request(16'h0000);
        send_request(16'h0001);
        send_request(16'hFFFF);

        // unused register index, must leave the others alone
        wait_idle();
        cfg_write(2'd3, $urandom);
        send_request(16'h1234);

        configure(32'hC0A8_0001, 32'hC0A8_00FE, ID_RESET);
        send_request(16'h5555);
        send_request(16'hAAAA);
        send_request(16'h00FF);
        send_request(16'hFF00);

        configure(32'h8000_0000, 32'h0000_0001, 16'h8000);
        send_request(16'h7FFF);
        send_request(16'h0001);

        random_phase(9, 49);
        random_phase(49, 9);
        random_phase(0, 0);

        wait_idle();
        repeat (8) @(negedge aclk);

        $display("covered %0d echo requests, %0d packet bytes compared, %0d register writes",
                 requests_seen, bytes_checked, config_writes);
        $display("idling on both sides, back-to-back packets, extreme addresses and ids");
        if (error_count == 0) begin
            $display("icmp_echo_packet_builder_core_tb: done, clean");
        end else begin
            $display("icmp_echo_packet_builder_core_tb: done, errors");
        end
        $finish;
    end

endmodule
